FILE: rtl/rpt_pkg.sv
package rpt_pkg;

	// table geometry
	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RES     = 17;

	// field widths
	localparam int ACT_W     = 2;
	localparam int KIND_W    = 3;
	localparam int SLOT_W    = 4;
	localparam int ID_W      = 16;
	localparam int CMD_W     = 16;
	localparam int TMO_W     = 16;
	localparam int RETRY_W   = 8;
	localparam int TAG_W     = 16;
	localparam int LEN_W     = 11;
	localparam int ELAPSED_W = 17;
	localparam int STEP_W    = 10;
	localparam int CNT_W     = 5;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 64;

	localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd100;

	typedef enum logic [ACT_W-1:0] {
		ACT_JOIN = 2'd0,
		ACT_ACK  = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_JOIN_OK       = 3'd0,
		KIND_DUPLICATE     = 3'd1,
		KIND_FULL          = 3'd2,
		KIND_ACK_MATCHED   = 3'd3,
		KIND_ACK_UNMATCHED = 3'd4,
		KIND_RESEND        = 3'd5,
		KIND_GAVE_UP       = 3'd6,
		KIND_TICK_DONE     = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // item accepted, latch its fields
		logic rd_first;  // read slot 0
		logic step;      // commit current slot, read next
		logic finish;    // emit closing result of the item
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic act_valid; // incoming action code is meaningful
		logic stall;     // slot wants to emit, output register busy
		logic last_slot; // slot under evaluation is the last one
		logic out_free;  // output register can take a result
	} ctrl_sts_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [CMD_W-1:0]     cmd;
		logic [TMO_W-1:0]     timeout;
		logic [ELAPSED_W-1:0] elapsed;
		logic [RETRY_W-1:0]   retries;
		logic [TAG_W-1:0]     tag;
		logic [LEN_W-1:0]     len;
	} row_t;

endpackage

FILE: rtl/retransmit_pending_table.sv
// table of packets waiting for an acknowledgement, keyed by (id, cmd)
//
// s_* channel: one item per request; tuser is the action (join, ack, tick),
// tdata carries key, timeout, retry budget and the stored packet's tag/len.
// m_* channel: results; tuser is the result kind, tlast marks the final
// result of an item. join and ack give exactly one result, a tick gives one
// resend or give-up result per expiring entry in slot order, then tick done.
// cfg_* channel: tick step in ms, always ready, write only while idle.
//
// every item sweeps all ENTRIES slots through the single read port of the
// entry memory, one slot per cycle while no result waits on m_tready; the
// final result becomes valid in the same cycle as s_tready rises, so a new
// item is taken only after the previous one has closed.
// s_tready is high only between items; an unused action code is accepted and
// produces nothing.
// if the receiver stalls, the sweep holds at the current slot until the
// output register frees up; no result is lost or repeated.
// reset clears all live bits and sets the tick step to 100 ms; the entry
// memory itself is not cleared, contents of free slots are never used.
module retransmit_pending_table #(
	parameter int ENTRIES = rpt_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [87:0] key_id, key_cmd, timeout_ms, retry_count, packet_tag, packet_len, pad
	input  logic [rpt_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] action
	input  logic [rpt_pkg::ACT_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [63:0] slot, out_id, out_cmd, out_tag, out_len, pad
	output logic [rpt_pkg::OUT_DATA_W-1:0] m_tdata,
	// [2:0] kind
	output logic [rpt_pkg::KIND_W-1:0]     m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	// tick_step_ms
	input  logic [rpt_pkg::STEP_W-1:0]     cfg_data
);
	import rpt_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// register write never waits
	assign cfg_ready = 1'b1;

	// sequencing: accept, prime read, sweep, closing result
	rpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry memory, live bits, slot evaluation and output register
	rpt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	// a real item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		(s_tuser == ACT_JOIN || s_tuser == ACT_ACK || s_tuser == ACT_TICK) |=> !s_tready)
		else $error("block ready right after taking an item");

	// closing result lands in the output register marked last
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid && m_tlast)
		else $error("closing result missing or not marked last");

	// the sweep cannot close before the last slot is committed
	a_no_early_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && !sts.last_slot |=> !cmd.finish)
		else $error("item closed before sweep ended");

endmodule

FILE: rtl/rpt_ctrl.sv
module rpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  rpt_pkg::ctrl_sts_t sts,
	output rpt_pkg::ctrl_cmd_t cmd
);
	import rpt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.act_valid) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.stall && sts.last_slot) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.rd_first = 1'b0;
		cmd.step     = 1'b0;
		cmd.finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_PRIME: begin
				cmd.rd_first = 1'b1;
			end
			ST_SCAN: begin
				cmd.step = !sts.stall;
			end
			ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/rpt_dpath.sv
module rpt_dpath #(
	parameter int ENTRIES = rpt_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rpt_pkg::ACT_W-1:0]      s_tuser,
	input  logic [rpt_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           cfg_valid,
	input  logic [rpt_pkg::STEP_W-1:0]     cfg_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rpt_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [rpt_pkg::KIND_W-1:0]     m_tuser,
	output logic                           m_tlast,
	input  rpt_pkg::ctrl_cmd_t             cmd,
	output rpt_pkg::ctrl_sts_t             sts
);
	import rpt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W+SLOT_W-1:0] w;
		begin
			w = {{SLOT_W{1'b0}}, i};
			return w[SLOT_W-1:0];
		end
	endfunction

	// config and latched item
	logic [STEP_W-1:0] step_q;
	logic [ACT_W-1:0]  act_q;
	logic [ID_W-1:0]   key_id_q;
	logic [CMD_W-1:0]  key_cmd_q;
	row_t              new_row_q;

	// table
	row_t              mem_q [ENTRIES];
	row_t              rd_row_q;
	logic [ENTRIES-1:0] live_q;

	// scan state
	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [CNT_W-1:0] emit_cnt_q;

	// output register
	logic              m_valid_q;
	logic [KIND_W-1:0] m_kind_q;
	logic [SLOT_W-1:0] m_slot_q;
	logic [ID_W-1:0]   m_id_q;
	logic [CMD_W-1:0]  m_cmd_q;
	logic [TAG_W-1:0]  m_tag_q;
	logic [LEN_W-1:0]  m_len_q;
	logic              m_last_q;

	// evaluation of the slot held in rd_row_q
	logic                 cur_live;
	logic                 key_match;
	logic [ELAPSED_W-1:0] sum;
	logic                 expire;
	logic                 tick_upd;
	logic                 give_up;
	logic                 emit_req;
	logic                 out_free;
	logic                 join_write;
	logic                 out_load;
	row_t                 tick_row;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	row_t                 wr_row;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;

	assign cur_live  = live_q[idx_q];
	assign key_match = cur_live && (rd_row_q.id == key_id_q) && (rd_row_q.cmd == key_cmd_q);
	assign sum       = rd_row_q.elapsed + ELAPSED_W'(step_q);
	assign expire    = sum >= ELAPSED_W'(rd_row_q.timeout);
	assign tick_upd  = (act_q == ACT_TICK) && cur_live;
	assign give_up   = tick_upd && expire && (rd_row_q.retries == '0);
	assign emit_req  = tick_upd && expire && (emit_cnt_q < CNT_W'(MAX_RES - 1));
	assign out_free  = !m_valid_q || m_tready;
	assign join_write = (act_q == ACT_JOIN) && !hit_q && free_q;
	assign out_load  = (cmd.step && emit_req) || cmd.finish;

	assign sts.act_valid = (s_tuser == ACT_JOIN) || (s_tuser == ACT_ACK) || (s_tuser == ACT_TICK);
	assign sts.stall     = emit_req && !out_free;
	assign sts.last_slot = idx_q == LAST_IDX;
	assign sts.out_free  = out_free;

	always_comb begin
		tick_row = rd_row_q;
		if (expire) begin
			tick_row.elapsed = '0;
			if (rd_row_q.retries != '0) begin
				tick_row.retries = rd_row_q.retries - RETRY_W'(1);
			end
		end else begin
			tick_row.elapsed = sum;
		end
	end

	assign wr_en   = (cmd.step && tick_upd) || (cmd.finish && join_write);
	assign wr_addr = cmd.finish ? free_idx_q : idx_q;
	assign wr_row  = cmd.finish ? new_row_q : tick_row;
	assign rd_en   = cmd.rd_first || (cmd.step && !sts.last_slot);
	assign rd_addr = cmd.rd_first ? '0 : idx_q + IDX_W'(1);

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= TICK_STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q             <= s_tuser;
			key_id_q          <= s_tdata[15:0];
			key_cmd_q         <= s_tdata[31:16];
			new_row_q.id      <= s_tdata[15:0];
			new_row_q.cmd     <= s_tdata[31:16];
			new_row_q.timeout <= s_tdata[47:32];
			new_row_q.elapsed <= '0;
			new_row_q.retries <= s_tdata[55:48];
			new_row_q.tag     <= s_tdata[71:56];
			new_row_q.len     <= s_tdata[82:72];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			emit_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				emit_cnt_q <= '0;
			end
			if (cmd.rd_first) begin
				idx_q <= '0;
			end
			if (cmd.step) begin
				if (!sts.last_slot) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (key_match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_q;
				end
				if (!cur_live && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (emit_req) begin
					emit_cnt_q <= emit_cnt_q + CNT_W'(1);
				end
				if (give_up) begin
					live_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.finish) begin
				if ((act_q == ACT_ACK) && hit_q) begin
					live_q[hit_idx_q] <= 1'b0;
				end
				if (join_write) begin
					live_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd.finish) begin
				m_id_q   <= '0;
				m_cmd_q  <= '0;
				m_tag_q  <= '0;
				m_len_q  <= '0;
				m_last_q <= 1'b1;
				case (act_q)
					ACT_JOIN: begin
						if (hit_q) begin
							m_kind_q <= KIND_DUPLICATE;
							m_slot_q <= to_slot(hit_idx_q);
						end else if (free_q) begin
							m_kind_q <= KIND_JOIN_OK;
							m_slot_q <= to_slot(free_idx_q);
						end else begin
							m_kind_q <= KIND_FULL;
							m_slot_q <= '0;
						end
					end
					ACT_ACK: begin
						if (hit_q) begin
							m_kind_q <= KIND_ACK_MATCHED;
							m_slot_q <= to_slot(hit_idx_q);
						end else begin
							m_kind_q <= KIND_ACK_UNMATCHED;
							m_slot_q <= '0;
						end
					end
					default: begin
						m_kind_q <= KIND_TICK_DONE;
						m_slot_q <= '0;
					end
				endcase
			end else begin
				m_kind_q <= give_up ? KIND_GAVE_UP : KIND_RESEND;
				m_slot_q <= to_slot(idx_q);
				m_id_q   <= rd_row_q.id;
				m_cmd_q  <= rd_row_q.cmd;
				m_tag_q  <= rd_row_q.tag;
				m_len_q  <= rd_row_q.len;
				m_last_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {1'b0, m_len_q, m_tag_q, m_cmd_q, m_id_q, m_slot_q};

endmodule

FILE: sim/retransmit_pending_table_tb.sv
module retransmit_pending_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpt_pkg::*;

	localparam int SLOTS         = ENTRIES_DEF;
	localparam int SETTLE_CYCLES = 40;      // covers the sweep of all entries, plus margin
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 38;
	localparam int DIR_N         = 17;

	// action code the block ignores
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// tdata bit offsets, lowest field first
	localparam int I_CMD = ID_W;
	localparam int I_TMO = I_CMD + CMD_W;
	localparam int I_RTY = I_TMO + TMO_W;
	localparam int I_TAG = I_RTY + RETRY_W;
	localparam int I_LEN = I_TAG + TAG_W;
	localparam int O_ID  = SLOT_W;
	localparam int O_CMD = O_ID + ID_W;
	localparam int O_TAG = O_CMD + CMD_W;
	localparam int O_LEN = O_TAG + TAG_W;

	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [ID_W-1:0]    id;
		logic [CMD_W-1:0]   cmd;
		logic [TMO_W-1:0]   tmo;
		logic [RETRY_W-1:0] rty;
		logic [TAG_W-1:0]   tag;
		logic [LEN_W-1:0]   len;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [CMD_W-1:0]  cmd;
		logic [TAG_W-1:0]  tag;
		logic [LEN_W-1:0]  len;
		logic              last;
	} result_t;

	// one line of the directed table; rep > 1 walks id, tag and len upward
	typedef struct packed {
		req_t              rq;
		logic [7:0]        rep;
		logic              typed;
		kind_t             t_kind;
		logic [SLOT_W-1:0] t_slot;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [ACT_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [STEP_W-1:0]     cfg_data = '0;

	// shadow of the pending table
	logic                 slot_live    [SLOTS];
	logic [ID_W-1:0]      slot_id      [SLOTS];
	logic [CMD_W-1:0]     slot_cmd     [SLOTS];
	logic [TMO_W-1:0]     slot_tmo     [SLOTS];
	logic [ELAPSED_W-1:0] slot_elapsed [SLOTS];
	logic [RETRY_W-1:0]   slot_retries [SLOTS];
	logic [TAG_W-1:0]     slot_tag     [SLOTS];
	logic [LEN_W-1:0]     slot_len     [SLOTS];
	logic [STEP_W-1:0]    tick_step;

	result_t  item_results [$];  // results of the item just accepted
	result_t  due_results  [$];  // results still to arrive, oldest first
	dir_row_t dir_rows [DIR_N];

	int fail_cnt  = 0;
	int cycle_cnt = 0;
	bit hold_out  = 1'b0;
	bit no_idle   = 1'b0;

	retransmit_pending_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	function automatic void add_result(kind_t kind, int slot, logic [ID_W-1:0] id,
			logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len,
			logic last);
		result_t r;
		r.kind = kind;
		r.slot = SLOT_W'(slot);
		r.id   = id;
		r.cmd  = cmd;
		r.tag  = tag;
		r.len  = len;
		r.last = last;
		if (item_results.size() < MAX_RES)
			item_results.push_back(r);
	endfunction

	function automatic void free_slot(int i);
		slot_live[i]    = 1'b0;
		slot_id[i]      = '0;
		slot_cmd[i]     = '0;
		slot_tmo[i]     = '0;
		slot_elapsed[i] = '0;
		slot_retries[i] = '0;
	endfunction

	// apply one accepted item to the shadow table, results go to item_results
	function automatic void table_update(req_t rq);
		logic [ELAPSED_W-1:0] sum;
		int hit;
		item_results.delete();
		hit = -1;
		if (rq.act == ACT_JOIN || rq.act == ACT_ACK) begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_live[i] && slot_id[i] == rq.id && slot_cmd[i] == rq.cmd)
					hit = i;
		end
		if (rq.act == ACT_JOIN) begin
			if (hit >= 0) begin
				add_result(KIND_DUPLICATE, hit, '0, '0, '0, '0, 1'b1);
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && !slot_live[i])
						hit = i;
				if (hit >= 0) begin
					slot_live[hit]    = 1'b1;
					slot_id[hit]      = rq.id;
					slot_cmd[hit]     = rq.cmd;
					slot_tmo[hit]     = rq.tmo;
					slot_retries[hit] = rq.rty;
					slot_elapsed[hit] = '0;
					slot_tag[hit]     = rq.tag;
					slot_len[hit]     = rq.len;
					add_result(KIND_JOIN_OK, hit, '0, '0, '0, '0, 1'b1);
				end else begin
					add_result(KIND_FULL, 0, '0, '0, '0, '0, 1'b1);
				end
			end
		end else if (rq.act == ACT_ACK) begin
			if (hit >= 0) begin
				free_slot(hit);
				add_result(KIND_ACK_MATCHED, hit, '0, '0, '0, '0, 1'b1);
			end else begin
				add_result(KIND_ACK_UNMATCHED, 0, '0, '0, '0, '0, 1'b1);
			end
		end else if (rq.act == ACT_TICK) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_live[i]) begin
					sum = slot_elapsed[i] + ELAPSED_W'(tick_step);
					if (sum >= ELAPSED_W'(slot_tmo[i])) begin
						slot_elapsed[i] = '0;
						if (slot_retries[i] == '0) begin
							// out of retries: report and release the entry
							add_result(KIND_GAVE_UP, i, slot_id[i], slot_cmd[i],
								slot_tag[i], slot_len[i], 1'b0);
							free_slot(i);
						end else begin
							slot_retries[i] = slot_retries[i] - 1'b1;
							add_result(KIND_RESEND, i, slot_id[i], slot_cmd[i],
								slot_tag[i], slot_len[i], 1'b0);
						end
					end else begin
						slot_elapsed[i] = sum;
					end
				end
			end
			// the closing result always fits
			if (item_results.size() >= MAX_RES)
				item_results.delete(item_results.size() - 1);
			add_result(KIND_TICK_DONE, 0, '0, '0, '0, '0, 1'b1);
		end
	endfunction

	function automatic dir_row_t row(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
			logic [CMD_W-1:0] cmd, logic [TMO_W-1:0] tmo, logic [RETRY_W-1:0] rty,
			logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic [7:0] rep,
			logic typed, kind_t t_kind, logic [SLOT_W-1:0] t_slot);
		dir_row_t d;
		d.rq.act = act;
		d.rq.id  = id;
		d.rq.cmd = cmd;
		d.rq.tmo = tmo;
		d.rq.rty = rty;
		d.rq.tag = tag;
		d.rq.len = len;
		d.rep    = rep;
		d.typed  = typed;
		d.t_kind = t_kind;
		d.t_slot = t_slot;
		return d;
	endfunction

	// random item; keys lean on live entries so acks and duplicates hit
	function automatic req_t rand_req();
		req_t rq;
		int live_idx [$];
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			rq.act = ACT_JOIN;
		else if (pick < 70)
			rq.act = ACT_ACK;
		else if (pick < 95)
			rq.act = ACT_TICK;
		else
			rq.act = ACT_UNUSED;
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i])
				live_idx.push_back(i);
		pick = $urandom_range(0, 99);
		if (live_idx.size() > 0 && ((rq.act == ACT_ACK && pick < 60) || pick < 20)) begin
			pick   = live_idx[$urandom_range(0, live_idx.size() - 1)];
			rq.id  = slot_id[pick];
			rq.cmd = slot_cmd[pick];
		end else if (pick < 70) begin
			rq.id  = ID_W'($urandom_range(0, 7));
			rq.cmd = CMD_W'($urandom_range(0, 3));
		end else begin
			rq.id  = ID_W'($urandom);
			rq.cmd = CMD_W'($urandom);
		end
		span = (tick_step < 50) ? 50 : int'(tick_step);
		case ($urandom_range(0, 9))
			0: rq.tmo = '0;
			1: rq.tmo = TMO_W'($urandom);
			default: rq.tmo = TMO_W'($urandom_range(0, 4 * span));
		endcase
		rq.rty = ($urandom_range(0, 9) == 0) ? RETRY_W'($urandom)
			: RETRY_W'($urandom_range(0, 3));
		rq.tag = TAG_W'($urandom);
		rq.len = LEN_W'($urandom);
		return rq;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	// offer one item, predict its results once the block takes it
	task automatic send_item(req_t rq, logic typed, result_t typed_res);
		logic [IN_DATA_W-1:0] d;
		int gap;
		d = '0;
		d[0 +: ID_W]        = rq.id;
		d[I_CMD +: CMD_W]   = rq.cmd;
		d[I_TMO +: TMO_W]   = rq.tmo;
		d[I_RTY +: RETRY_W] = rq.rty;
		d[I_TAG +: TAG_W]   = rq.tag;
		d[I_LEN +: LEN_W]   = rq.len;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= rq.act;
		do @(posedge clk); while (!s_tready);
		table_update(rq);
		if (typed) begin
			due_results.push_back(typed_res);
		end else begin
			foreach (item_results[i])
				due_results.push_back(item_results[i]);
		end
	endtask

	// stop offering and wait for every outstanding result plus the sweep tail
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(logic [STEP_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tick_step = v;
	endtask

	// result sink with random back-pressure and an optional long hold-off
	initial begin
		int n;
		wait (arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 7);
			if (hold_out) begin
				n = HOLD_CYCLES;
				hold_out = 1'b0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result checker, samples the values in front of the edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d", m_tuser, m_tdata[SLOT_W-1:0]);
				fail_cnt++;
			end else begin
				want = due_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_tuser));
				check_field("slot", 32'(want.slot), 32'(m_tdata[SLOT_W-1:0]));
				check_field("out_id", 32'(want.id), 32'(m_tdata[O_ID +: ID_W]));
				check_field("out_cmd", 32'(want.cmd), 32'(m_tdata[O_CMD +: CMD_W]));
				check_field("out_tag", 32'(want.tag), 32'(m_tdata[O_TAG +: TAG_W]));
				check_field("out_len", 32'(want.len), 32'(m_tdata[O_LEN +: LEN_W]));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_t              rq;
		result_t           tr;
		logic [STEP_W-1:0] phase_step;

		tick_step = TICK_STEP_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			free_slot(i);
			slot_tag[i] = '0;
			slot_len[i] = '0;
		end

		// directed table, run with the reset tick step of 100 ms
		dir_rows[0]  = row(ACT_ACK, 16'h1, 16'h1, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_ACK_UNMATCHED, 4'd0);
		dir_rows[1]  = row(ACT_TICK, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_TICK_DONE, 4'd0);
		// all-ones key, zero timeout and no retries: gives up on the next tick
		dir_rows[2]  = row(ACT_JOIN, 16'hffff, 16'hffff, 16'h0, 8'h0, 16'hffff, 11'h7ff, 8'd1,
			1'b1, KIND_JOIN_OK, 4'd0);
		dir_rows[3]  = row(ACT_JOIN, 16'hffff, 16'hffff, 16'h5, 8'h5, 16'h5, 11'h5, 8'd1,
			1'b1, KIND_DUPLICATE, 4'd0);
		dir_rows[4]  = row(ACT_JOIN, 16'h0, 16'h0, 16'hffff, 8'hff, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_JOIN_OK, 4'd1);
		dir_rows[5]  = row(ACT_JOIN, 16'h5, 16'h5, 16'd100, 8'h1, 16'h1234, 11'h155, 8'd1,
			1'b1, KIND_JOIN_OK, 4'd2);
		dir_rows[6]  = row(ACT_TICK, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b0, KIND_TICK_DONE, 4'd0);
		dir_rows[7]  = row(ACT_ACK, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_ACK_MATCHED, 4'd1);
		dir_rows[8]  = row(ACT_JOIN, 16'h0, 16'h0, 16'd200, 8'h2, 16'haaaa, 11'h2aa, 8'd1,
			1'b1, KIND_JOIN_OK, 4'd0);
		// fill every remaining slot
		dir_rows[9]  = row(ACT_JOIN, 16'h100, 16'h20, 16'h0, 8'hff, 16'h8000, 11'h400, 8'd14,
			1'b0, KIND_JOIN_OK, 4'd0);
		dir_rows[10] = row(ACT_JOIN, 16'habcd, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_FULL, 4'd0);
		// duplicate wins over full
		dir_rows[11] = row(ACT_JOIN, 16'h5, 16'h5, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_DUPLICATE, 4'd2);
		dir_rows[12] = row(ACT_UNUSED, 16'hffff, 16'hffff, 16'hffff, 8'hff, 16'hffff, 11'h7ff,
			8'd1, 1'b0, KIND_TICK_DONE, 4'd0);
		dir_rows[13] = row(ACT_TICK, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b0, KIND_TICK_DONE, 4'd0);
		dir_rows[14] = row(ACT_JOIN, 16'h7, 16'h7, 16'h0, 8'h3, 16'h7777, 11'h77, 8'd1,
			1'b1, KIND_JOIN_OK, 4'd2);
		// full table, every slot expires: sixteen resends and the done item
		dir_rows[15] = row(ACT_TICK, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b0, KIND_TICK_DONE, 4'd0);
		dir_rows[16] = row(ACT_ACK, 16'h5, 16'h5, 16'h0, 8'h0, 16'h0, 11'h0, 8'd1,
			1'b1, KIND_ACK_UNMATCHED, 4'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			for (int k = 0; k < int'(dir_rows[r].rep); k++) begin
				rq      = dir_rows[r].rq;
				rq.id   = rq.id + ID_W'(k);
				rq.tag  = rq.tag + TAG_W'(k);
				rq.len  = rq.len + LEN_W'(k);
				tr      = '0;
				tr.kind = dir_rows[r].t_kind;
				tr.slot = dir_rows[r].t_slot;
				tr.last = 1'b1;
				send_item(rq, dir_rows[r].typed, tr);
			end
		end

		// random phases, each under its own tick step
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_step = 10'd1023;
				1: phase_step = 10'd0;
				2: phase_step = 10'd1;
				3: phase_step = 10'd500;
				default: phase_step = STEP_W'($urandom_range(1, 1000));
			endcase
			write_step(phase_step);
			no_idle = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver stalls for a long stretch while items keep coming
				if (ph == 0 && n == 5)
					hold_out = 1'b1;
				// sender waits until the block has delivered everything
				if (ph == 2 && n == 19)
					drain();
				send_item(rand_req(), 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		drain();
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
